// File: rtl/dlz_pkg.sv
// ----------------------------------------------------------------------------
// dlz_pkg
// shared types and constants of the line rasterizer with depth test
// ----------------------------------------------------------------------------
package dlz_pkg;

  localparam int unsigned ImageWidth   = 256;
  localparam int unsigned ImageHeight  = 256;
  localparam int unsigned DepthBits    = 16;
  localparam int unsigned FractionBits = 16;

  localparam int unsigned CoordW = 8;
  localparam int unsigned InDepthW = 16;
  localparam int unsigned ColorW = 32;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic                cmd;
    logic [CoordW-1:0]   sx;
    logic [CoordW-1:0]   sy;
    logic [InDepthW-1:0] sz;
    logic [CoordW-1:0]   ex;
    logic [CoordW-1:0]   ey;
    logic [InDepthW-1:0] ez;
    logic [ColorW-1:0]   color;
    logic                zen;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STEP,
    ST_READ,
    ST_OUT,
    ST_CLEAR
  } state_e;

endpackage

// File: rtl/dlz_if.sv
// ----------------------------------------------------------------------------
// dlz_in_if / dlz_out_if
// valid-ready channels of the line rasterizer
// ----------------------------------------------------------------------------
interface dlz_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [dlz_pkg::CoordW-1:0]    start_x;
  logic [dlz_pkg::CoordW-1:0]    start_y;
  logic [dlz_pkg::InDepthW-1:0]  start_depth;
  logic [dlz_pkg::CoordW-1:0]    end_x;
  logic [dlz_pkg::CoordW-1:0]    end_y;
  logic [dlz_pkg::InDepthW-1:0]  end_depth;
  logic [dlz_pkg::ColorW-1:0]    line_color;
  logic                          depth_enable;
  modport source (output valid, command, start_x, start_y, start_depth, end_x, end_y,
                  end_depth, line_color, depth_enable, input ready);
  modport sink (input valid, command, start_x, start_y, start_depth, end_x, end_y,
                end_depth, line_color, depth_enable, output ready);
endinterface

interface dlz_out_if;
  logic                       valid;
  logic                       ready;
  logic                       pixel_write;
  logic [dlz_pkg::CoordW-1:0] pixel_x;
  logic [dlz_pkg::CoordW-1:0] pixel_y;
  logic [dlz_pkg::ColorW-1:0] pixel_color;
  logic                       last_pixel;
  modport source (output valid, pixel_write, pixel_x, pixel_y, pixel_color, last_pixel,
                  input ready);
  modport sink (input valid, pixel_write, pixel_x, pixel_y, pixel_color, last_pixel,
                output ready);
endinterface

// File: rtl/dlz_ram.sv
// ----------------------------------------------------------------------------
// dlz_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module dlz_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end
endmodule

// File: rtl/dlz_front.sv
// ----------------------------------------------------------------------------
// dlz_front
// accepts commands and queues them for the back end
// ----------------------------------------------------------------------------
module dlz_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  dlz_in_if.sink        in_if,
  output dlz_pkg::cmd_t q_data_o,
  output logic          q_valid_o,
  input  logic          q_pop_i
);
  localparam int unsigned Depth = 2;

  dlz_pkg::cmd_t   fifo_q [Depth];
  logic            wp_q, rp_q;
  logic [1:0]      cnt_q;
  dlz_pkg::cmd_t   item;
  logic            push;

  always_comb begin
    item.cmd   = in_if.command;
    item.sx    = in_if.start_x;
    item.sy    = in_if.start_y;
    item.sz    = in_if.start_depth;
    item.ex    = in_if.end_x;
    item.ey    = in_if.end_y;
    item.ez    = in_if.end_depth;
    item.color = in_if.line_color;
    item.zen   = in_if.depth_enable;
  end

  assign in_if.ready = (cnt_q != 2'(Depth));
  assign push        = in_if.valid && in_if.ready;
  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_data_o    = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

// File: rtl/dlz_back.sv
// ----------------------------------------------------------------------------
// dlz_back
// line setup with serial divider, pixel walk and depth store update
// ----------------------------------------------------------------------------
module dlz_back #(
  parameter int unsigned ImageWidth   = dlz_pkg::ImageWidth,
  parameter int unsigned ImageHeight  = dlz_pkg::ImageHeight,
  parameter int unsigned DepthBits    = dlz_pkg::DepthBits,
  parameter int unsigned FractionBits = dlz_pkg::FractionBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dlz_pkg::cmd_t q_data_i,
  input  logic          q_valid_i,
  output logic          q_pop_o,
  dlz_out_if.source     out_if
);
  localparam int unsigned XW    = (ImageWidth > 1) ? $clog2(ImageWidth) : 1;
  localparam int unsigned YW    = (ImageHeight > 1) ? $clog2(ImageHeight) : 1;
  localparam int unsigned AW    = XW + YW;
  localparam int unsigned Depth = 1 << AW;
  localparam int unsigned CW    = dlz_pkg::CoordW;
  localparam int unsigned ZW    = dlz_pkg::InDepthW;
  localparam int unsigned NumW  = ZW + FractionBits + 1;       // signed numerator
  localparam int unsigned MinW  = CW + FractionBits + 1;       // minor accumulator
  localparam int unsigned AccZW = ZW + FractionBits + 2;       // depth accumulator
  localparam int unsigned DivCntW = $clog2(NumW + 1);
  localparam logic [DepthBits-1:0] ZMax = '1;

  dlz_pkg::state_e state_q, state_d;

  logic              xmaj_q;
  logic [CW-1:0]     maj_q, majend_q;
  logic [MinW-1:0]   macc_q, mslope_q;
  logic [AccZW-1:0]  zacc_q, zslope_q;
  logic [31:0]       color_q;
  logic              zen_q;
  logic              active_q;

  // serial divider
  logic [NumW-1:0]    dz_q, dm_q;          // magnitudes being divided
  logic [NumW-1:0]    rz_q, rm_q;
  logic               negz_q, negm_q;
  logic [CW-1:0]      den_q;
  logic [DivCntW-1:0] dcnt_q;

  // clearing pass
  logic [AW:0]        clr_q;

  // step pipeline
  logic [CW-1:0]      px_q, py_q;
  logic               inb_q, last_q;
  logic [DepthBits-1:0] z_q;

  // output register
  logic               ov_q, ow_q, olast_q;
  logic [CW-1:0]      ox_q, oy_q;
  logic [31:0]        ocol_q;

  // ram
  logic               we;
  logic [AW-1:0]      addr;
  logic [DepthBits-1:0] wdata, rdata;

  dlz_ram #(.Width(DepthBits), .Depth(Depth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  // setup decode
  logic [CW:0] adx, ady;
  logic        xm;
  logic [CW-1:0] ma1, ma2, mi1, mi2;
  logic [ZW-1:0] z1, z2;
  logic          sw;
  logic signed [CW:0]  dmi;
  logic signed [ZW:0]  dzz;

  always_comb begin
    adx = (q_data_i.ex >= q_data_i.sx) ? {1'b0, q_data_i.ex - q_data_i.sx}
                                        : {1'b0, q_data_i.sx - q_data_i.ex};
    ady = (q_data_i.ey >= q_data_i.sy) ? {1'b0, q_data_i.ey - q_data_i.sy}
                                        : {1'b0, q_data_i.sy - q_data_i.ey};
    xm  = adx > ady;
    ma1 = xm ? q_data_i.sx : q_data_i.sy;
    ma2 = xm ? q_data_i.ex : q_data_i.ey;
    mi1 = xm ? q_data_i.sy : q_data_i.sx;
    mi2 = xm ? q_data_i.ey : q_data_i.ex;
    z1  = q_data_i.sz;
    z2  = q_data_i.ez;
    sw  = ma1 > ma2;
    if (sw) begin
      {ma1, ma2} = {ma2, ma1};
      {mi1, mi2} = {mi2, mi1};
      {z1, z2}   = {z2, z1};
    end
    dmi = $signed({1'b0, mi2}) - $signed({1'b0, mi1});
    dzz = $signed({1'b0, z2}) - $signed({1'b0, z1});
  end

  // divider step: restoring, one quotient bit per cycle for both slopes
  logic [NumW:0] trz, trm;
  logic [NumW-1:0] rz_n, rm_n, qz_n, qm_n;
  always_comb begin
    trz  = {rz_q, dz_q[NumW-1]};
    trm  = {rm_q, dm_q[NumW-1]};
    qz_n = {dz_q[NumW-2:0], 1'b0};
    qm_n = {dm_q[NumW-2:0], 1'b0};
    rz_n = trz[NumW-1:0];
    rm_n = trm[NumW-1:0];
    if (trz >= {{(NumW+1-CW){1'b0}}, den_q}) begin
      rz_n = NumW'(trz - {{(NumW+1-CW){1'b0}}, den_q});
      qz_n[0] = 1'b1;
    end
    if (trm >= {{(NumW+1-CW){1'b0}}, den_q}) begin
      rm_n = NumW'(trm - {{(NumW+1-CW){1'b0}}, den_q});
      qm_n[0] = 1'b1;
    end
  end

  // pixel of the current step
  logic [CW-1:0] minor_i, cx, cy;
  logic [AccZW-FractionBits-1:0] zint;
  logic [DepthBits-1:0] zsat;
  logic inb;
  always_comb begin
    minor_i = macc_q[MinW-1] ? '0 : macc_q[FractionBits +: CW];
    cx = xmaj_q ? maj_q : minor_i;
    cy = xmaj_q ? minor_i : maj_q;
    inb = ({24'd0, cx} < 32'(ImageWidth)) && ({24'd0, cy} < 32'(ImageHeight));
    zint = zacc_q[AccZW-1] ? '0 : zacc_q[AccZW-1:FractionBits];
    if (64'(zint) > 64'(ZMax)) zsat = ZMax;
    else zsat = DepthBits'(zint);
  end

  logic out_free;
  assign out_free = !ov_q || out_if.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dlz_pkg::ST_CLEAR: if (clr_q[AW]) state_d = dlz_pkg::ST_IDLE;
      dlz_pkg::ST_IDLE: begin
        if (q_valid_i) begin
          if (q_data_i.cmd == dlz_pkg::CMD_START) state_d = dlz_pkg::ST_DIV;
          else if (active_q) state_d = dlz_pkg::ST_READ;
        end
      end
      dlz_pkg::ST_DIV:  if (dcnt_q == '0) state_d = dlz_pkg::ST_STEP;
      dlz_pkg::ST_STEP: state_d = dlz_pkg::ST_IDLE;
      dlz_pkg::ST_READ: state_d = dlz_pkg::ST_OUT;
      dlz_pkg::ST_OUT:  if (out_free) state_d = dlz_pkg::ST_IDLE;
      default:          state_d = dlz_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o = 1'b0;
    we      = 1'b0;
    addr    = {YW'(cy), XW'(cx)};
    wdata   = zsat;
    unique case (state_q)
      dlz_pkg::ST_CLEAR: begin
        we    = 1'b1;
        addr  = clr_q[AW-1:0];
        wdata = ZMax;
      end
      dlz_pkg::ST_IDLE: q_pop_o = q_valid_i && !(q_data_i.cmd == dlz_pkg::CMD_START);
      dlz_pkg::ST_STEP: q_pop_o = 1'b1;
      dlz_pkg::ST_OUT: begin
        addr  = {YW'(py_q), XW'(px_q)};
        wdata = z_q;
        we    = out_free && inb_q && zen_q && (z_q <= rdata);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dlz_pkg::ST_IDLE && q_valid_i && q_data_i.cmd == dlz_pkg::CMD_START) begin
      xmaj_q   <= xm;
      maj_q    <= ma1;
      majend_q <= ma2;
      macc_q   <= MinW'({mi1, {FractionBits{1'b0}}});
      zacc_q   <= AccZW'({z1, {FractionBits{1'b0}}});
      color_q  <= q_data_i.color;
      zen_q    <= q_data_i.zen;
      den_q    <= ma2 - ma1;
      negm_q   <= dmi[CW];
      negz_q   <= dzz[ZW];
      dm_q     <= NumW'({(dmi[CW] ? CW'(-dmi) : CW'(dmi)), {FractionBits{1'b0}}});
      dz_q     <= NumW'({(dzz[ZW] ? ZW'(-dzz) : ZW'(dzz)), {FractionBits{1'b0}}});
      rm_q     <= '0;
      rz_q     <= '0;
      dcnt_q   <= DivCntW'(NumW);
    end else if (state_q == dlz_pkg::ST_DIV) begin
      if (dcnt_q != '0) begin
        dz_q   <= qz_n;
        dm_q   <= qm_n;
        rz_q   <= rz_n;
        rm_q   <= rm_n;
        dcnt_q <= dcnt_q - 1'b1;
      end
    end else if (state_q == dlz_pkg::ST_STEP) begin
      if (den_q == '0) begin
        mslope_q <= '0;
        zslope_q <= '0;
      end else begin
        mslope_q <= negm_q ? -MinW'(dm_q) : MinW'(dm_q);
        zslope_q <= negz_q ? -AccZW'(dz_q) : AccZW'(dz_q);
      end
    end else if (state_q == dlz_pkg::ST_READ) begin
      px_q   <= cx;
      py_q   <= cy;
      inb_q  <= inb;
      z_q    <= zsat;
      last_q <= maj_q >= majend_q;
      if (maj_q < majend_q) begin
        maj_q  <= maj_q + 1'b1;
        macc_q <= macc_q + mslope_q;
        zacc_q <= zacc_q + zslope_q;
      end
    end
    if (state_q == dlz_pkg::ST_OUT && out_free) begin
      ow_q    <= inb_q && (!zen_q || (z_q <= rdata));
      ox_q    <= px_q;
      oy_q    <= py_q;
      ocol_q  <= color_q;
      olast_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= dlz_pkg::ST_CLEAR;
      clr_q    <= '0;
      active_q <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == dlz_pkg::ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == dlz_pkg::ST_STEP) active_q <= 1'b1;
      if (state_q == dlz_pkg::ST_OUT && out_free && last_q) active_q <= 1'b0;
      if (state_q == dlz_pkg::ST_OUT && out_free) ov_q <= 1'b1;
      else if (out_if.ready) ov_q <= 1'b0;
    end
  end

  assign out_if.valid       = ov_q;
  assign out_if.pixel_write = ow_q;
  assign out_if.pixel_x     = ox_q;
  assign out_if.pixel_y     = oy_q;
  assign out_if.pixel_color = ocol_q;
  assign out_if.last_pixel  = olast_q;
endmodule

// File: rtl/dda_line_with_depth_test_core.sv
// ----------------------------------------------------------------------------
// dda_line_with_depth_test_core
// line rasterizer with 16.16 slopes and a per pixel depth store
// ----------------------------------------------------------------------------
// usage:
//   in_if carries commands: a start transaction loads endpoints, depths, color
//   and depth enable and gives no result; each step transaction gives one pixel
//   on out_if while a line is active, and nothing when idle.
//   a two entry queue sits between the command front end and the back end.
//   a step passes the back end states idle, read and out: depth store read, then
//   compare and write; the single ported depth store keeps these apart.
//   a start passes the states idle, div and step: a bit serial divider
//   forms both slopes, one quotient bit per cycle.
//   after reset the depth store is cleared to all ones, one entry a cycle,
//   before commands run.
//   a stalled out_if holds its result; the back end waits, the queue fills and
//   in_if ready drops.
// ----------------------------------------------------------------------------
module dda_line_with_depth_test_core #(
  parameter int unsigned ImageWidth   = dlz_pkg::ImageWidth,
  parameter int unsigned ImageHeight  = dlz_pkg::ImageHeight,
  parameter int unsigned DepthBits    = dlz_pkg::DepthBits,
  parameter int unsigned FractionBits = dlz_pkg::FractionBits
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dlz_in_if.sink     in_if,
  dlz_out_if.source  out_if
);
  dlz_pkg::cmd_t q_data;
  logic          q_valid, q_pop;

  dlz_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_if     (in_if),
    .q_data_o  (q_data),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  dlz_back #(
    .ImageWidth   (ImageWidth),
    .ImageHeight  (ImageHeight),
    .DepthBits    (DepthBits),
    .FractionBits (FractionBits)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (q_data),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .out_if    (out_if)
  );
endmodule
